FILE: rtl/vector_store_with_norms_core_defines.svh
// ----------------------------------------------------------------------------
// Vector store with norms: assertion macros
// Shared concurrent assertion forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR_STORE_WITH_NORMS_CORE_DEFINES_SVH
`define VECTOR_STORE_WITH_NORMS_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VSN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VSN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vsn_pkg.sv
// ----------------------------------------------------------------------------
// Vector store with norms: package
// Widths, codes and inter-module structs.
// ----------------------------------------------------------------------------
package vsn_pkg;

  localparam int MAX_LENGTH = 16;

  localparam int DATA_W = 16;
  localparam int IDX_W  = 8;
  localparam int CFG_W  = 5;
  localparam int EUC_W  = 18;
  localparam int MAXA_W = 16;

  localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int CNT_W  = $clog2(MAX_LENGTH + 1);

  // compare widths for mixed-width checks
  localparam int LCMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ICMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  // squares and their sum
  localparam int SQ_W   = 2 * DATA_W - 1;
  localparam int SUM_W  = SQ_W + $clog2(MAX_LENGTH);
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int RCMP_W = (ROOT_W > EUC_W) ? ROOT_W : EUC_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
  localparam logic [EUC_W-1:0] EUC_MAX   = '1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
    logic                     ok;
    logic [CNT_W-1:0]         len;
  } vsn_start_t;

  typedef struct packed {
    logic [SUM_W-1:0]         sum;
    logic [MAXA_W-1:0]        max_abs;
    logic signed [DATA_W-1:0] rdata;
  } vsn_norm_t;

endpackage

FILE: rtl/vsn_if.sv
// ----------------------------------------------------------------------------
// Vector store with norms: stream interfaces
// Item and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vsn_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [vsn_pkg::IDX_W-1:0]        index;
  logic signed [vsn_pkg::DATA_W-1:0] value;

  modport source (output valid, output kind, output index, output value, input ready);
  modport sink   (input valid, input kind, input index, input value, output ready);
endinterface

interface vsn_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vsn_pkg::DATA_W-1:0] read_data;
  logic                              index_ok;
  logic [vsn_pkg::EUC_W-1:0]         euclid_norm;
  logic [vsn_pkg::MAXA_W-1:0]        max_abs_norm;

  modport source (output valid, output read_data, output index_ok, output euclid_norm,
                  output max_abs_norm, input ready);
  modport sink   (input valid, input read_data, input index_ok, input euclid_norm,
                  input max_abs_norm, output ready);
endinterface

FILE: rtl/vsn_sqrt.sv
// ----------------------------------------------------------------------------
// Vector store with norms: serial square root
// Restoring square root, one radicand bit pair and one root bit per cycle.
// ----------------------------------------------------------------------------
module vsn_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [vsn_pkg::SUM_W-1:0]    radicand,
  output logic                         done,
  output logic [vsn_pkg::EUC_W-1:0]    root
);

  localparam int RAD_W  = 2 * vsn_pkg::ROOT_W;
  localparam int STEP_W = $clog2(vsn_pkg::ROOT_W + 1);

  logic [RAD_W-1:0]             rad_r, rad_nxt;
  logic [vsn_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [vsn_pkg::ROOT_W-1:0]   root_r, root_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;

  logic [vsn_pkg::REM_W-1:0]    rem_sh;
  logic [vsn_pkg::REM_W-1:0]    trial;
  logic                         fits;

  // next partial remainder and trial subtrahend 4*root+1
  assign rem_sh = {rem_r[vsn_pkg::REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = RAD_W'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = fits ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[vsn_pkg::ROOT_W-2:0], fits};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(vsn_pkg::ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
      root_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
      root_r <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  // clamp to the result field
  assign root = (vsn_pkg::RCMP_W'(root_r) > vsn_pkg::RCMP_W'(vsn_pkg::EUC_MAX)) ?
                vsn_pkg::EUC_MAX : vsn_pkg::EUC_W'(root_r);

endmodule

FILE: rtl/vsn_norm.sv
// ----------------------------------------------------------------------------
// Vector store with norms: element store and norm walk
// Holds the elements, applies the write, then walks the live elements one per
// cycle for the sum of squares, the largest magnitude and the read data.
// ----------------------------------------------------------------------------
module vsn_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  vsn_pkg::vsn_start_t  cmd,
  output logic                 done,
  output vsn_pkg::vsn_norm_t   res
);

  localparam int CNT_W = vsn_pkg::CNT_W;

  logic signed [vsn_pkg::DATA_W-1:0] store_r [vsn_pkg::MAX_LENGTH];

  logic [CNT_W-1:0]                  cnt_r;
  logic [CNT_W-1:0]                  len_r;
  logic                              busy_r;
  logic                              sq_vld_r;
  logic                              last_r;
  logic                              done_r;
  logic [vsn_pkg::SQ_W-1:0]          sq_r;
  logic [vsn_pkg::SUM_W-1:0]         sum_r;
  logic [vsn_pkg::MAXA_W-1:0]        max_r;
  logic signed [vsn_pkg::DATA_W-1:0] rdata_r;
  logic                              kind_r;
  logic                              ok_r;
  logic [vsn_pkg::IDX_W-1:0]         idx_r;

  logic signed [vsn_pkg::DATA_W-1:0] elem;
  logic [vsn_pkg::MAXA_W-1:0]        mag;
  logic [2*vsn_pkg::MAXA_W-1:0]      prod;
  logic                              hit;

  assign elem = store_r[cnt_r[vsn_pkg::ADDR_W-1:0]];
  assign mag  = elem[vsn_pkg::DATA_W-1] ? (~vsn_pkg::MAXA_W'(elem) + vsn_pkg::MAXA_W'(1))
                                         : vsn_pkg::MAXA_W'(elem);
  assign prod = mag * mag;
  assign hit  = ok_r && (kind_r == vsn_pkg::KIND_READ) &&
                (vsn_pkg::ICMP_W'(cnt_r) == vsn_pkg::ICMP_W'(idx_r));

  // element store, written only at item start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vsn_pkg::MAX_LENGTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (start && cmd.ok && (cmd.kind == vsn_pkg::KIND_WRITE)) begin
      store_r[cmd.idx[vsn_pkg::ADDR_W-1:0]] <= cmd.value;
    end
  end

  // walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      sq_vld_r <= 1'b0;
      last_r   <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r   <= 1'b0;
      sq_vld_r <= 1'b0;
      if (start) begin
        cnt_r  <= '0;
        busy_r <= (cmd.len != '0);
        done_r <= (cmd.len == '0);
      end else begin
        if (busy_r) begin
          cnt_r    <= cnt_r + CNT_W'(1);
          sq_vld_r <= 1'b1;
          last_r   <= ((cnt_r + CNT_W'(1)) == len_r);
          if ((cnt_r + CNT_W'(1)) == len_r) begin
            busy_r <= 1'b0;
          end
        end
        if (sq_vld_r && last_r) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: magnitude and square, then accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      len_r   <= cmd.len;
      kind_r  <= cmd.kind;
      ok_r    <= cmd.ok;
      idx_r   <= cmd.idx;
      sum_r   <= '0;
      max_r   <= '0;
      rdata_r <= '0;
    end else begin
      if (busy_r) begin
        sq_r <= vsn_pkg::SQ_W'(prod);
        if (mag > max_r) begin
          max_r <= mag;
        end
        if (hit) begin
          rdata_r <= elem;
        end
      end
      if (sq_vld_r) begin
        sum_r <= sum_r + vsn_pkg::SUM_W'(sq_r);
      end
    end
  end

  assign done        = done_r;
  assign res.sum     = sum_r;
  assign res.max_abs = max_r;
  assign res.rdata   = rdata_r;

endmodule

FILE: rtl/vector_store_with_norms_core.sv
// ----------------------------------------------------------------------------
// Vector store with norms: top level
// Element store with per-item Euclidean and maximum norms.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : items {kind, index, value}; kind 0 writes value at index, kind 1
//            reads index. Indexes at or above the length are ignored.
//   out_ch : one result per item {read_data, index_ok, euclid_norm,
//            max_abs_norm}; norms cover elements 0..L-1 after the write.
//   cfg_we/cfg_wdata : vector length, taken on any edge with cfg_we high;
//            write it only while no item is in flight. L = min(length, 16).
//   Path : each item's elements go one per cycle through the norm walk
//            (one 16x16 square per cycle), then the restoring square root
//            retires one root bit per cycle.
//   Flow : one item in flight at a time; in_ch.ready is high only between
//            items, so a new item is taken once the previous result sits in
//            the output register, even while it waits.
//   Stall : a finished root waits in place until the output register frees.
//   Reset : elements clear to zero, length returns to 16, channels empty.
// ----------------------------------------------------------------------------
`include "vector_store_with_norms_core_defines.svh"

module vector_store_with_norms_core (
  input  logic                      clk,
  input  logic                      rst_n,
  vsn_in_if.sink                    in_ch,
  vsn_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [vsn_pkg::CFG_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_HOLD = 4'b1000
  } vsn_state_t;

  vsn_state_t state_r, state_nxt;

  logic [vsn_pkg::CFG_W-1:0]          len_cfg_r;
  logic [vsn_pkg::CNT_W-1:0]          eff_len;

  logic                               accept;
  logic                               ok;
  vsn_pkg::vsn_start_t                cmd;
  logic                               norm_done;
  vsn_pkg::vsn_norm_t                 norm_res;
  logic                               root_done;
  logic [vsn_pkg::EUC_W-1:0]          root;

  // results held from transfer (index flag) or walk end until output load
  logic signed [vsn_pkg::DATA_W-1:0]  rdata_r;
  logic                               ok_r;
  logic [vsn_pkg::MAXA_W-1:0]         max_r;

  // output register
  logic                               out_valid_r;
  logic signed [vsn_pkg::DATA_W-1:0]  out_rdata_r;
  logic                               out_ok_r;
  logic [vsn_pkg::EUC_W-1:0]          out_euc_r;
  logic [vsn_pkg::MAXA_W-1:0]         out_max_r;

  logic                               out_free;
  logic                               load;

  // length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= vsn_pkg::CFG_RESET;
    end else if (cfg_we) begin
      len_cfg_r <= cfg_wdata;
    end
  end

  // saturate length to the store depth
  assign eff_len = (vsn_pkg::LCMP_W'(len_cfg_r) > vsn_pkg::LCMP_W'(vsn_pkg::MAX_LENGTH)) ?
                   vsn_pkg::CNT_W'(vsn_pkg::MAX_LENGTH) : vsn_pkg::CNT_W'(len_cfg_r);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign ok          = (vsn_pkg::ICMP_W'(in_ch.index) < vsn_pkg::ICMP_W'(eff_len));

  assign cmd.kind  = in_ch.kind;
  assign cmd.idx   = in_ch.index;
  assign cmd.value = in_ch.value;
  assign cmd.ok    = ok;
  assign cmd.len   = eff_len;

  vsn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .cmd   (cmd),
    .done  (norm_done),
    .res   (norm_res)
  );

  vsn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (norm_done),
    .radicand (norm_res.sum),
    .done     (root_done),
    .root     (root)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign load     = ((state_r == ST_ROOT) && root_done && out_free) ||
                    ((state_r == ST_HOLD) && out_free);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept)    state_nxt = ST_WALK;
      ST_WALK: if (norm_done) state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: if (out_free)  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r <= ok;
    end
    if (norm_done) begin
      rdata_r <= norm_res.rdata;
      max_r   <= norm_res.max_abs;
    end
    if (load) begin
      out_rdata_r <= rdata_r;
      out_ok_r    <= ok_r;
      out_euc_r   <= root;
      out_max_r   <= max_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_rdata_r;
  assign out_ch.index_ok     = out_ok_r;
  assign out_ch.euclid_norm  = out_euc_r;
  assign out_ch.max_abs_norm = out_max_r;

  `VSN_ASSERT_SAME(a_walk_done_in_walk, norm_done, state_r == ST_WALK, "walk done outside walk")
  `VSN_ASSERT_SAME(a_root_done_in_root, root_done, state_r == ST_ROOT, "root done outside root")
  `VSN_ASSERT_NEXT(a_accept_starts_walk, accept, state_r == ST_WALK, "transfer did not start walk")
  `VSN_ASSERT_SAME(a_bad_index_no_data, out_ch.valid && !out_ch.index_ok,
                   out_ch.read_data == '0, "read data on bad index")
  `VSN_ASSERT_SAME(a_max_in_range, out_ch.valid, out_ch.max_abs_norm <= 16'h8000,
                   "max norm out of range")

endmodule

FILE: bench/tb_vector_store_with_norms_core.sv
// ----------------------------------------------------------------------------
// Vector store with norms: testbench
// Drives write/read items through the input channel and checks every result
// (read data, index flag, Euclidean and max norms) against a local model of
// the element store, over a sweep of vector lengths with random stalls.
// ----------------------------------------------------------------------------
module tb_vector_store_with_norms_core;

  typedef struct packed {
    logic                              kind;
    logic [vsn_pkg::IDX_W-1:0]         index;
    logic signed [vsn_pkg::DATA_W-1:0] value;
  } vec_item_t;

  typedef struct packed {
    logic signed [vsn_pkg::DATA_W-1:0] read_data;
    logic                              index_ok;
    logic [vsn_pkg::EUC_W-1:0]         euclid;
    logic [vsn_pkg::MAXA_W-1:0]        max_abs;
  } norm_result_t;

  localparam int NUM_PHASES   = 11;
  localparam int PHASE_ITEMS  = 180;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int LIMIT_CYCLES = 1_000_000;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [vsn_pkg::CFG_W-1:0] cfg_wdata;

  vsn_in_if  in_ch ();
  vsn_out_if out_ch ();

  vector_store_with_norms_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Model state: element store and length register, as after reset.
  logic signed [vsn_pkg::DATA_W-1:0] elem_model [vsn_pkg::MAX_LENGTH] = '{default: '0};
  logic [vsn_pkg::CFG_W-1:0]         model_len = vsn_pkg::CFG_RESET;

  vec_item_t    pending_items [$];
  norm_result_t expected_norms [$];

  int  mismatches   = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  bit  in_idle_on   = 1'b1;
  bit  out_idle_on  = 1'b1;
  bit  hold_start   = 1'b0;
  bit  hold_on      = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic log_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Applies one item to the model store and returns the result it causes.
  function automatic norm_result_t apply_item(input vec_item_t it);
    norm_result_t     r;
    int unsigned      eff;
    int               e;
    int               i;
    int               b;
    longint unsigned  a;
    longint unsigned  sum_sq;
    longint unsigned  max_a;
    longint unsigned  root;
    longint unsigned  trial;
    eff = (model_len > vsn_pkg::MAX_LENGTH) ? vsn_pkg::MAX_LENGTH : model_len;
    r = '0;
    r.index_ok = (it.index < eff);
    if (r.index_ok) begin
      if (it.kind == vsn_pkg::KIND_WRITE) begin
        elem_model[it.index[vsn_pkg::ADDR_W-1:0]] = it.value;
      end else begin
        r.read_data = elem_model[it.index[vsn_pkg::ADDR_W-1:0]];
      end
    end
    sum_sq = 0;
    max_a  = 0;
    for (i = 0; i < eff; i++) begin
      e = int'(elem_model[i]);
      a = 64'((e < 0) ? -e : e);
      sum_sq += a * a;
      if (a > max_a) max_a = a;
    end
    // floor square root, one bit at a time from the top
    root = 0;
    for (b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    if (root > vsn_pkg::EUC_MAX) root = vsn_pkg::EUC_MAX;
    r.euclid  = root[vsn_pkg::EUC_W-1:0];
    r.max_abs = max_a[vsn_pkg::MAXA_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Item driver. The offered item is held until its transfer; the model is
  // updated at the transfer edge and the expected result queued.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : item_driver
    int        in_gap;
    vec_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.kind  <= vsn_pkg::KIND_WRITE;
      in_ch.index <= '0;
      in_ch.value <= '0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        it.kind  = in_ch.kind;
        it.index = in_ch.index;
        it.value = in_ch.value;
        expected_norms.push_back(apply_item(it));
        items_sent++;
      end
      // Next offer, decided once per edge so valid gets one assignment.
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (in_idle_on && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 13);
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_ch.kind  <= it.kind;
          in_ch.index <= it.index;
          in_ch.value <= it.value;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, counted here once the stimulus asks for it.
  // --------------------------------------------------------------------------
  initial begin : long_hold
    wait (hold_start);
    hold_on = 1'b1;
    repeat (LONG_HOLD) @(negedge clk);
    hold_on = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Result monitor. Checks each transfer against the oldest expectation and
  // drives ready: random stall bursts, plus the long hold-off that lets the
  // block fill up and push back on its input.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    int           out_gap;
    norm_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_norms.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_norms.pop_front();
          if (out_ch.read_data !== want.read_data)
            log_mismatch($sformatf("result %0d read_data %0d, expected %0d",
                                   results_seen, out_ch.read_data, want.read_data));
          if (out_ch.index_ok !== want.index_ok)
            log_mismatch($sformatf("result %0d index_ok %0b, expected %0b",
                                   results_seen, out_ch.index_ok, want.index_ok));
          if (out_ch.euclid_norm !== want.euclid)
            log_mismatch($sformatf("result %0d euclid_norm %0d, expected %0d",
                                   results_seen, out_ch.euclid_norm, want.euclid));
          if (out_ch.max_abs_norm !== want.max_abs)
            log_mismatch($sformatf("result %0d max_abs_norm %0d, expected %0d",
                                   results_seen, out_ch.max_abs_norm, want.max_abs));
        end
        results_seen++;
      end
      if (hold_on) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (out_idle_on && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic add_item(input logic kind, input int index, input int value);
    vec_item_t it;
    it.kind  = kind;
    it.index = index[vsn_pkg::IDX_W-1:0];
    it.value = value[vsn_pkg::DATA_W-1:0];
    pending_items.push_back(it);
  endtask

  // Sender pause: nothing queued, nothing offered, every result back.
  // Sampled on the falling edge so all edge updates have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_norms.size() != 0);
  endtask

  // Length register write, only while the block is drained.
  task automatic write_length(input logic [vsn_pkg::CFG_W-1:0] len);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    model_len  = len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [vsn_pkg::CFG_W-1:0] lengths [NUM_PHASES];
    int                        p;
    int                        n;
    int                        eff;
    int                        idx;
    int                        val;
    logic                      kind;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset length: zero store, extremes of value,
    // boundary and top index for writes and reads, then the most negative value
    // in every element but 0 for a near-maximal sum of squares.
    @(negedge clk);
    add_item(vsn_pkg::KIND_READ,  0,   0);
    add_item(vsn_pkg::KIND_WRITE, 0,   32767);
    add_item(vsn_pkg::KIND_WRITE, 15, -32768);
    add_item(vsn_pkg::KIND_WRITE, 16,  1234);   // out of range, ignored
    add_item(vsn_pkg::KIND_WRITE, 255, -1);     // out of range, ignored
    add_item(vsn_pkg::KIND_READ,  0,   0);
    add_item(vsn_pkg::KIND_READ,  15,  0);
    add_item(vsn_pkg::KIND_READ,  16,  0);
    add_item(vsn_pkg::KIND_READ,  255, -1);
    for (n = 1; n < 15; n++) add_item(vsn_pkg::KIND_WRITE, n, -32768);
    add_item(vsn_pkg::KIND_READ,  7,   0);
    wait_drained();

    // Length sweep: shrink to one, zero, back to full (old elements return),
    // saturating values above the maximum, and a few in between. The last
    // phase runs with no idling on either side.
    lengths = '{5'd1, 5'd0, 5'd16, 5'd8, 5'd31, 5'd17, 5'd5, 5'd2, 5'd12, 5'd1, 5'd16};
    for (p = 0; p < NUM_PHASES; p++) begin
      write_length(lengths[p]);
      eff = (lengths[p] > vsn_pkg::MAX_LENGTH) ? vsn_pkg::MAX_LENGTH : lengths[p];
      if (p == NUM_PHASES - 1) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end
      @(negedge clk);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        kind = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0:       idx = $urandom_range(0, 255);
          1:       idx = eff;
          default: idx = $urandom_range(0, vsn_pkg::MAX_LENGTH - 1);
        endcase
        case ($urandom_range(0, 7))
          0:       val = -32768;
          1:       val = 32767;
          2:       val = 0;
          3:       val = $urandom_range(0, 511) - 256;
          default: val = $urandom;
        endcase
        add_item(kind, idx, val);
      end
      // One long receiver hold-off while the items keep coming.
      if (p == 2) hold_start = 1'b1;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_norms.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", expected_norms.size()));

    $display("Summary: %0d items over %0d length settings, %0d results checked",
             items_sent, NUM_PHASES + 1, results_seen);
    $display("Summary: lengths 0..31 incl. saturation, long output hold, random stalls");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin : run_limit
    #(LIMIT_CYCLES * 8);
    $display("Timeout: %0d items sent, %0d results seen", items_sent, results_seen);
    $display("Mismatches found");
    $finish;
  end

endmodule
